// File: rtl/core/dia_pkg.sv
// types and constants shared by the dotted ipv4 address parser
// no dependencies
package dia_pkg;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_ZERO   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_OK     = 5'b01000,
        PH_BAD    = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        phase_t          phase;
        radix_t          radix;
        logic [31:0]     acc;
        logic [2:0][7:0] parts;
        logic [1:0]      count;
    } parse_state_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
    } parse_res_t;

    localparam parse_state_t ST_RESET = '{
        phase: PH_START,
        radix: RX_DEC,
        acc:   32'd0,
        parts: 24'd0,
        count: 2'd0
    };

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A_UP  = 8'h41;
    localparam logic [7:0] CHAR_F_UP  = 8'h46;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;
    localparam logic [7:0] CHAR_A_LO  = 8'h61;
    localparam logic [7:0] CHAR_F_LO  = 8'h66;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;

    localparam logic [31:0] LIM_TWO_PART   = 32'h00ff_ffff;
    localparam logic [31:0] LIM_THREE_PART = 32'h0000_ffff;
    localparam logic [31:0] LIM_FOUR_PART  = 32'h0000_00ff;

    localparam logic [1:0] MAX_SAVED = 2'd3;

endpackage

// File: rtl/core/dia_step.sv
// next-state logic of the parser for one character
// depends on dia_pkg
module dia_step import dia_pkg::*; (
    input  parse_state_t st_i,
    input  logic [7:0]   char_i,
    output parse_state_t st_o,
    output parse_res_t   res_o
);

    // close the address using the saved parts and the final part
    function automatic parse_state_t finish_addr(parse_state_t s);
        parse_state_t r;
        logic         ok;
        logic [31:0]  v;
        r  = s;
        v  = s.acc;
        ok = 1'b1;
        case (s.count)
            2'd0: ok = 1'b1;
            2'd1: begin
                if (s.acc > LIM_TWO_PART) ok = 1'b0;
                else v = s.acc | {s.parts[0], 24'd0};
            end
            2'd2: begin
                if (s.acc > LIM_THREE_PART) ok = 1'b0;
                else v = s.acc | {s.parts[0], s.parts[1], 16'd0};
            end
            default: begin
                if (s.acc > LIM_FOUR_PART) ok = 1'b0;
                else v = s.acc | {s.parts[0], s.parts[1], s.parts[2], 8'd0};
            end
        endcase
        r.acc   = ok ? v : 32'd0;
        r.phase = ok ? PH_OK : PH_BAD;
        return r;
    endfunction

    // one character inside the digit run of a part
    function automatic parse_state_t digit_step(parse_state_t s, logic [7:0] c);
        parse_state_t r;
        logic [31:0]  shifted;
        logic [31:0]  hex_shift;
        logic         is_dec;
        logic         is_hex_up;
        logic         is_hex_lo;
        r         = s;
        hex_shift = {s.acc[27:0], 4'd0};
        case (s.radix)
            RX_HEX:  shifted = hex_shift;
            RX_OCT:  shifted = {s.acc[28:0], 3'd0};
            default: shifted = {s.acc[28:0], 3'd0} + {s.acc[30:0], 1'b0};
        endcase
        is_dec    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_hex_up = (s.radix == RX_HEX) && (c >= CHAR_A_UP) && (c <= CHAR_F_UP);
        is_hex_lo = (s.radix == RX_HEX) && (c >= CHAR_A_LO) && (c <= CHAR_F_LO);
        if (is_dec) begin
            r.acc = shifted + {24'd0, c - CHAR_ZERO};
        end else if (is_hex_up) begin
            r.acc = hex_shift + {24'd0, c - CHAR_A_UP + 8'd10};
        end else if (is_hex_lo) begin
            r.acc = hex_shift + {24'd0, c - CHAR_A_LO + 8'd10};
        end else if (c == CHAR_DOT) begin
            if (s.count == MAX_SAVED || s.acc > LIM_FOUR_PART) begin
                r.acc   = 32'd0;
                r.phase = PH_BAD;
            end else begin
                r.parts[s.count] = s.acc[7:0];
                r.count          = s.count + 2'd1;
                r.acc            = 32'd0;
                r.radix          = RX_DEC;
                r.phase          = PH_START;
            end
        end else if (c == CHAR_SPACE) begin
            r = finish_addr(s);
        end else begin
            r.acc   = 32'd0;
            r.phase = PH_BAD;
        end
        return r;
    endfunction

    parse_state_t work;
    parse_state_t fin;

    always_comb begin
        work  = st_i;
        fin   = st_i;
        st_o  = st_i;
        res_o = '0;
        if (char_i == CHAR_NUL) begin
            if (st_i.phase == PH_START || st_i.phase == PH_ZERO
                    || st_i.phase == PH_DIGITS) begin
                fin = finish_addr(st_i);
            end
            res_o.ok   = (fin.phase == PH_OK);
            res_o.addr = (fin.phase == PH_OK) ? fin.acc : 32'd0;
            st_o       = ST_RESET;
        end else begin
            unique case (st_i.phase)
                PH_START: begin
                    work.acc = 32'd0;
                    if (char_i == CHAR_ZERO) begin
                        work.radix = RX_OCT;
                        work.phase = PH_ZERO;
                        st_o       = work;
                    end else begin
                        work.radix = RX_DEC;
                        work.phase = PH_DIGITS;
                        st_o       = digit_step(work, char_i);
                    end
                end
                PH_ZERO: begin
                    work.phase = PH_DIGITS;
                    if (char_i == CHAR_X_UP || char_i == CHAR_X_LO) begin
                        work.radix = RX_HEX;
                        st_o       = work;
                    end else begin
                        work.radix = RX_OCT;
                        st_o       = digit_step(work, char_i);
                    end
                end
                PH_DIGITS: st_o = digit_step(st_i, char_i);
                default:   st_o = st_i;
            endcase
        end
    end

endmodule

// File: rtl/core/dotted_ipv4_address_parser_unit.sv
// Dotted IPv4 address text parser. Characters arrive one per request on the s_ channel
// and are taken at one per cycle, but a string end waits while the result slot is full;
// every character goes through an input register and one pass of next-state logic (a
// per-radix shift-add on the 32-bit accumulator), so the rate is set by that single
// accumulator update. A NUL closes the string: once it is in the input register and the
// result slot is free, a result request is registered and offered on the m_ channel with
// the valid flag and the address (first part in the top byte), address 0 if invalid.
// A result waiting on m_ready does not stop further characters until the next NUL.
// top level, depends on dia_pkg and dia_step
module dotted_ipv4_address_parser_unit import dia_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [31:0] m_address
);

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    parse_state_t st_reg;
    parse_state_t st_next;
    parse_res_t   res_next;
    logic         m_valid_reg;
    logic         m_valid_res_reg;
    logic [31:0]  m_address_reg;
    logic         out_free;
    logic         is_nul;
    logic         proc_go;

    dia_step u_step (
        .st_i   (st_reg),
        .char_i (in_char_reg),
        .st_o   (st_next),
        .res_o  (res_next)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign is_nul   = (in_char_reg == CHAR_NUL);
    // only the string end needs a free output slot
    assign proc_go  = in_valid_reg && (!is_nul || out_free);
    assign s_ready  = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= ST_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (proc_go) st_reg <= st_next;
            if (proc_go && is_nul) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_char_reg <= s_char_code;
        if (proc_go && is_nul) begin
            m_valid_res_reg <= res_next.ok;
            m_address_reg   <= res_next.addr;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_valid_res = m_valid_res_reg;
    assign m_address   = m_address_reg;

    // an invalid address is always reported as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_valid_res_reg || m_address_reg == 32'd0))
        else $error("invalid result with non-zero address");

    // string end returns the parser to its initial state
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_go && is_nul |=> (st_reg == ST_RESET))
        else $error("state not cleared after string end");

    // accumulator is clear at the start of a part and after a bad character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == PH_START || st_reg.phase == PH_BAD) |-> (st_reg.acc == 32'd0))
        else $error("accumulator not clear");

    // a pending result is never dropped while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_address_reg))
        else $error("pending result lost");

    // a string end is held back while the result slot is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && is_nul && m_valid_reg && !m_ready |-> !proc_go)
        else $error("string end processed into a full result slot");

endmodule

// File: test/dotted_ipv4_address_parser_unit_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the dotted ipv4 address parser: random and directed address text
// in, parsed address and valid flag checked against a local parser; depends on dia_pkg
module dotted_ipv4_address_parser_unit_tb;
    import dia_pkg::*;

    localparam int TEXT_CHARS  = 1350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 15;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_valid_res;
    logic [31:0] m_address;

    dotted_ipv4_address_parser_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .m_address   (m_address)
    );

    logic [7:0] char_backlog [$];
    parse_res_t parsed_addr_q [$];

    // local parser state
    phase_t      ph;
    radix_t      rx;
    logic [31:0] acc;
    logic [7:0]  saved [3];
    logic [1:0]  nsaved;

    int cycle_count   = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int valid_seen    = 0;
    int chars_taken   = 0;
    int stall_cycles  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int tx_gap        = 0;
    int rx_gap        = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_parser();
        ph     = PH_START;
        rx     = RX_DEC;
        acc    = 32'd0;
        saved  = '{8'd0, 8'd0, 8'd0};
        nsaved = 2'd0;
    endfunction

    // join the saved parts with the final one, judging its width by the form
    function automatic void close_address();
        logic [31:0] v;
        logic        ok;
        v  = acc;
        ok = 1'b1;
        case (nsaved)
            2'd0: ;
            2'd1: if (v > LIM_TWO_PART) ok = 1'b0;
                  else v = v | {saved[0], 24'd0};
            2'd2: if (v > LIM_THREE_PART) ok = 1'b0;
                  else v = v | {saved[0], saved[1], 16'd0};
            default: if (v > LIM_FOUR_PART) ok = 1'b0;
                  else v = v | {saved[0], saved[1], saved[2], 8'd0};
        endcase
        acc = ok ? v : 32'd0;
        ph  = ok ? PH_OK : PH_BAD;
    endfunction

    function automatic void take_digit_char(logic [7:0] c);
        logic [31:0] mul;
        mul = (rx == RX_HEX) ? 32'd16 : (rx == RX_OCT) ? 32'd8 : 32'd10;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            acc = acc * mul + 32'(c - CHAR_ZERO);
        end else if (rx == RX_HEX && c >= CHAR_A_UP && c <= CHAR_F_UP) begin
            acc = (acc << 4) + 32'(c - CHAR_A_UP) + 32'd10;
        end else if (rx == RX_HEX && c >= CHAR_A_LO && c <= CHAR_F_LO) begin
            acc = (acc << 4) + 32'(c - CHAR_A_LO) + 32'd10;
        end else if (c == CHAR_DOT) begin
            if (nsaved == MAX_SAVED || acc > 32'd255) begin
                acc = 32'd0;
                ph  = PH_BAD;
            end else begin
                saved[nsaved] = acc[7:0];
                nsaved = nsaved + 2'd1;
                acc = 32'd0;
                rx  = RX_DEC;
                ph  = PH_START;
            end
        end else if (c == CHAR_SPACE) begin
            close_address();
        end else begin
            acc = 32'd0;
            ph  = PH_BAD;
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        parse_res_t res;
        if (c == CHAR_NUL) begin
            if (ph == PH_START || ph == PH_ZERO || ph == PH_DIGITS) close_address();
            res.ok   = (ph == PH_OK);
            res.addr = (ph == PH_OK) ? acc : 32'd0;
            parsed_addr_q.push_back(res);
            clear_parser();
        end else begin
            case (ph)
                PH_START: begin
                    acc = 32'd0;
                    if (c == CHAR_ZERO) begin
                        rx = RX_OCT;
                        ph = PH_ZERO;
                    end else begin
                        rx = RX_DEC;
                        ph = PH_DIGITS;
                        take_digit_char(c);
                    end
                end
                PH_ZERO: begin
                    ph = PH_DIGITS;
                    if (c == CHAR_X_LO || c == CHAR_X_UP) begin
                        rx = RX_HEX;
                    end else begin
                        rx = RX_OCT;
                        take_digit_char(c);
                    end
                end
                PH_DIGITS: take_digit_char(c);
                default: ;
            endcase
        end
    endfunction

    // quiet windows with no idling on either side
    function automatic int draw_gap();
        return ((cycle_count % 3000) >= 2200) ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) char_backlog.push_back(s[i]);
    endfunction

    function automatic void push_junk(int n);
        repeat (n) char_backlog.push_back(8'($urandom_range(1, 255)));
    endfunction

    // mostly well-formed addresses in random radices, some broken or pure noise
    function automatic void add_random_string();
        int          kind;
        int          n_parts;
        int          r;
        logic [31:0] v;
        string       digits;
        logic [7:0]  c;
        kind = $urandom_range(0, 11);
        if (kind == 0) begin
            push_junk($urandom_range(1, 8));
        end else begin
            n_parts = (kind == 1) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            for (int p = 0; p < n_parts; p++) begin
                if (p > 0) char_backlog.push_back(CHAR_DOT);
                if ($urandom_range(0, 19) == 0) continue;
                if (p == n_parts - 1 && $urandom_range(0, 2) == 0)
                    v = $urandom() >> $urandom_range(0, 31);
                else if ($urandom_range(0, 9) == 0)
                    v = $urandom_range(256, 4095);
                else
                    v = $urandom_range(0, 255);
                r = $urandom_range(0, 2);
                if (r == 0 && $urandom_range(0, 15) == 0) begin
                    // long decimal run that can wrap the accumulator
                    char_backlog.push_back(8'($urandom_range(1, 9) + CHAR_ZERO));
                    repeat ($urandom_range(9, 11))
                        char_backlog.push_back(8'($urandom_range(0, 9) + CHAR_ZERO));
                end else if (r == 0) begin
                    push_text($sformatf("%0d", v));
                end else if (r == 1) begin
                    char_backlog.push_back(CHAR_ZERO);
                    push_text($sformatf("%0o", v));
                    if ($urandom_range(0, 5) == 0)
                        char_backlog.push_back(8'($urandom_range(8, 9) + CHAR_ZERO));
                end else begin
                    char_backlog.push_back(CHAR_ZERO);
                    char_backlog.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
                    digits = ($urandom_range(0, 7) == 0) ? "" : $sformatf("%0h", v);
                    for (int i = 0; i < digits.len(); i++) begin
                        c = digits[i];
                        if (c >= CHAR_A_LO && $urandom_range(0, 1)) c = c - 8'd32;
                        char_backlog.push_back(c);
                    end
                end
            end
            if (kind == 2) begin
                char_backlog.push_back(CHAR_SPACE);
                push_junk($urandom_range(0, 6));
            end else if (kind == 3) begin
                push_junk($urandom_range(1, 6));
            end
        end
        char_backlog.push_back(CHAR_NUL);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sender: one request per character, random gap after each
    always @(posedge aclk) begin : drive_chars
        logic       nv;
        logic [7:0] nc;
        nv = s_valid;
        nc = s_char_code;
        if (!aresetn) begin
            nv = 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && !s_ready) stall_cycles++;
            if (s_valid && s_ready) begin
                parse_char(s_char_code);
                chars_taken++;
                nv = 1'b0;
                tx_gap = draw_gap();
            end
            if (!nv) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (char_backlog.size() > 0) begin
                    nv = 1'b1;
                    nc = char_backlog.pop_front();
                end
            end
        end
        s_valid     <= nv;
        s_char_code <= nc;
    end

    // one long hold-off on the result side so the block backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && results_seen == HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: compare each result with the oldest parsed address
    always @(posedge aclk) begin : take_results
        logic       nr;
        parse_res_t want;
        nr = m_ready;
        if (!aresetn) begin
            nr = 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (m_valid_res === 1'b1) valid_seen++;
                if (parsed_addr_q.size() == 0) begin
                    $error("result with nothing pending: valid_res %0b address %h",
                           m_valid_res, m_address);
                    mismatches++;
                end else begin
                    want = parsed_addr_q.pop_front();
                    if (m_valid_res !== want.ok) begin
                        $error("valid_res: expected %0b, actual %0b", want.ok, m_valid_res);
                        mismatches++;
                    end
                    if (m_address !== want.addr) begin
                        $error("address: expected %h, actual %h", want.addr, m_address);
                        mismatches++;
                    end
                end
                rx_gap = draw_gap();
            end
            if (rx_gap > 0) begin
                rx_gap--;
                nr = 1'b0;
            end else begin
                nr = (hold_left == 0);
            end
        end
        m_ready <= nr;
    end

    initial begin
        clear_parser();
        // empty string, octal with 9, hex both cases, space then a high code
        char_backlog.push_back(CHAR_NUL);
        push_text("09.0XaF.1 ");
        char_backlog.push_back(8'hff);
        char_backlog.push_back(CHAR_NUL);
        // fourth dot, wrapping decimal, non-final part over 255, lone high code
        push_text("1.2.3.4.");
        char_backlog.push_back(CHAR_NUL);
        push_text("9999999999");
        char_backlog.push_back(CHAR_NUL);
        push_text("256.1");
        char_backlog.push_back(CHAR_NUL);
        char_backlog.push_back(8'h80);
        char_backlog.push_back(CHAR_NUL);
        while (char_backlog.size() < TEXT_CHARS) add_random_string();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // sample mid-cycle so the driver's updates have all settled
        while (char_backlog.size() != 0 || s_valid || parsed_addr_q.size() != 0)
            @(negedge aclk);
        repeat (12) @(posedge aclk);

        $display("parsed %0d strings (%0d valid, %0d rejected) from %0d characters",
                 results_seen, valid_seen, results_seen - valid_seen, chars_taken);
        $display("input stalled for %0d cycles, including one %0d-cycle result hold-off",
                 stall_cycles, HOLD_CYCLES);
        if (mismatches == 0 && parsed_addr_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
